// File: rtl/fts_pkg.sv
// Shared types and constants of the frame timing statistics block.
`timescale 1ns / 1ps

package fts_pkg;

	localparam int STAMP_BITS      = 48;
	localparam int SCALE_FRAC_BITS = 8;
	localparam int RATE_BITS       = 32;
	localparam int COUNT_BITS      = 32;
	localparam int SCALE_BITS      = 16;
	localparam int SCALED_BITS     = 56;
	localparam int TOTAL_BITS      = 64;
	localparam int TPS_BITS        = 32;
	localparam int CFG_ADDR_BITS   = 8;
	localparam int DIV_BITS        = 64;
	localparam int DIV_CNT_BITS    = 7;

	localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_WIDE   = 7'd64;
	localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_NARROW = 7'd32;

	localparam logic [CFG_ADDR_BITS-1:0] REG_TICKS_PER_SECOND = 8'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TIME_SCALE       = 8'd1;

	localparam logic [TPS_BITS-1:0]   TPS_RESET   = 32'd1000000;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd256;
	localparam logic [RATE_BITS-1:0]  RATE_MAX    = {RATE_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP1,
		ST_STEP2,
		ST_STEP3,
		ST_WAIT_RATE,
		ST_SECS,
		ST_WAIT_SECS,
		ST_MINMAX,
		ST_WAIT_MEAN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIV_RATE,
		DIV_SECS,
		DIV_MEAN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     step1;
		logic     step2;
		logic     step3;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_rate;
		logic     take_secs;
		logic     minmax;
		logic     mean_sat;
		logic     take_mean;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic kind_clear;
		logic delta_zero;
		logic tps_zero;
		logic elapsed_zero;
		logic div_done;
		logic out_blocked;
	} status_t;

endpackage

// File: rtl/fts_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fts_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             narrow,
	input  logic [fts_pkg::DIV_BITS-1:0]     dividend,
	input  logic [fts_pkg::DIV_BITS-1:0]     divisor,
	output logic                             done,
	output logic [fts_pkg::DIV_BITS-1:0]     quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [fts_pkg::DIV_CNT_BITS-1:0]    cnt_q;
	logic [fts_pkg::DIV_BITS-1:0]        rem_q;
	logic [fts_pkg::DIV_BITS-1:0]        dvd_q;
	logic [fts_pkg::DIV_BITS-1:0]        dvs_q;
	logic [fts_pkg::DIV_BITS:0]          shifted;
	logic [fts_pkg::DIV_BITS:0]          trial;
	logic                                ge;

	assign shifted = {rem_q, dvd_q[fts_pkg::DIV_BITS-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= narrow ? fts_pkg::DIV_STEPS_NARROW : fts_pkg::DIV_STEPS_WIDE;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dvd_q <= narrow ? {dividend[31:0], 32'd0} : dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[fts_pkg::DIV_BITS-1:0] : shifted[fts_pkg::DIV_BITS-1:0];
			dvd_q <= {dvd_q[fts_pkg::DIV_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: rtl/fts_datapath.sv
// Datapath: configuration, statistics state, scaling multiplier and shared divider.
`timescale 1ns / 1ps

module fts_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [fts_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [fts_pkg::TPS_BITS-1:0]        cfg_wdata,
	input  logic [47:0]                         s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [479:0]                        m_tdata,
	input  fts_pkg::cmd_t                       cmd,
	output fts_pkg::status_t                    status
);

	logic [fts_pkg::TPS_BITS-1:0]     tps_q;
	logic [fts_pkg::SCALE_BITS-1:0]   scale_q;
	logic                             kind_q;
	logic [fts_pkg::STAMP_BITS-1:0]   stamp_q;
	logic [fts_pkg::STAMP_BITS-1:0]   last_stamp_q;
	logic [fts_pkg::STAMP_BITS-1:0]   delta_q;
	logic [fts_pkg::SCALED_BITS-1:0]  scaled_q;
	logic [fts_pkg::SCALED_BITS-1:0]  smooth_q;
	logic [fts_pkg::TOTAL_BITS-1:0]   raw_elapsed_q;
	logic [fts_pkg::TOTAL_BITS-1:0]   scaled_total_q;
	logic [fts_pkg::TOTAL_BITS-1:0]   whole_second_q;
	logic [fts_pkg::TOTAL_BITS-1:0]   mean_num_q;
	logic [fts_pkg::COUNT_BITS-1:0]   frame_count_q;
	logic [fts_pkg::COUNT_BITS-1:0]   count_at_second_q;
	logic [fts_pkg::RATE_BITS-1:0]    instant_rate_q;
	logic [fts_pkg::RATE_BITS-1:0]    second_rate_q;
	logic [fts_pkg::RATE_BITS-1:0]    lowest_rate_q;
	logic [fts_pkg::RATE_BITS-1:0]    highest_rate_q;
	logic [fts_pkg::RATE_BITS-1:0]    mean_rate_q;
	logic                             out_valid_q;
	logic [479:0]                     out_data_q;

	logic [63:0]                      product;
	logic [fts_pkg::SCALED_BITS:0]    smooth_sum;
	logic [fts_pkg::DIV_BITS-1:0]     div_dividend;
	logic [fts_pkg::DIV_BITS-1:0]     div_divisor;
	logic                             div_narrow;
	logic                             div_done;
	logic [fts_pkg::DIV_BITS-1:0]     div_quotient;

	assign product    = {16'd0, delta_q} * {48'd0, scale_q};
	assign smooth_sum = {1'b0, smooth_q} + {1'b0, scaled_q};

	always_comb begin
		div_dividend = {32'd0, tps_q};
		div_divisor  = {16'd0, delta_q};
		div_narrow   = 1'b1;
		case (cmd.div_sel)
			fts_pkg::DIV_RATE: begin
				div_dividend = {32'd0, tps_q};
				div_divisor  = {16'd0, delta_q};
				div_narrow   = 1'b1;
			end
			fts_pkg::DIV_SECS: begin
				div_dividend = raw_elapsed_q;
				div_divisor  = {32'd0, tps_q};
				div_narrow   = 1'b0;
			end
			fts_pkg::DIV_MEAN: begin
				div_dividend = mean_num_q;
				div_divisor  = raw_elapsed_q;
				div_narrow   = 1'b0;
			end
			default: begin
				div_dividend = {32'd0, tps_q};
				div_divisor  = {16'd0, delta_q};
				div_narrow   = 1'b1;
			end
		endcase
	end

	fts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.narrow   (div_narrow),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= fts_pkg::TPS_RESET;
			scale_q <= fts_pkg::SCALE_RESET;
		end else if (cfg_wen) begin
			if (cfg_addr == fts_pkg::REG_TICKS_PER_SECOND) begin
				tps_q <= cfg_wdata;
			end else if (cfg_addr == fts_pkg::REG_TIME_SCALE) begin
				scale_q <= cfg_wdata[fts_pkg::SCALE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q      <= '0;
			smooth_q          <= '0;
			raw_elapsed_q     <= '0;
			scaled_total_q    <= '0;
			frame_count_q     <= '0;
			count_at_second_q <= '0;
			whole_second_q    <= '0;
			instant_rate_q    <= '0;
			second_rate_q     <= '0;
			lowest_rate_q     <= fts_pkg::RATE_MAX;
			highest_rate_q    <= '0;
			mean_rate_q       <= '0;
		end else begin
			if (cmd.clear) begin
				raw_elapsed_q     <= '0;
				scaled_total_q    <= '0;
				frame_count_q     <= '0;
				count_at_second_q <= '0;
				whole_second_q    <= '0;
				instant_rate_q    <= '0;
				second_rate_q     <= '0;
				lowest_rate_q     <= fts_pkg::RATE_MAX;
				highest_rate_q    <= '0;
				mean_rate_q       <= '0;
			end
			if (cmd.step1) begin
				last_stamp_q <= stamp_q;
			end
			if (cmd.step2) begin
				raw_elapsed_q <= raw_elapsed_q + {16'd0, delta_q};
				frame_count_q <= frame_count_q + 1'b1;
			end
			if (cmd.step3) begin
				scaled_total_q <= scaled_total_q + {8'd0, scaled_q};
				smooth_q       <= smooth_sum[fts_pkg::SCALED_BITS:1];
			end
			if (cmd.take_rate) begin
				instant_rate_q <= div_quotient[fts_pkg::RATE_BITS-1:0];
			end
			if (cmd.take_secs && (div_quotient != whole_second_q)) begin
				second_rate_q     <= frame_count_q - count_at_second_q;
				count_at_second_q <= frame_count_q;
				whole_second_q    <= div_quotient;
			end
			if (cmd.minmax) begin
				if (instant_rate_q < lowest_rate_q) begin
					lowest_rate_q <= instant_rate_q;
				end
				if (instant_rate_q > highest_rate_q) begin
					highest_rate_q <= instant_rate_q;
				end
			end
			if (cmd.mean_sat) begin
				mean_rate_q <= fts_pkg::RATE_MAX;
			end
			if (cmd.take_mean) begin
				mean_rate_q <= (|div_quotient[63:32]) ? fts_pkg::RATE_MAX
				                                      : div_quotient[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= s_tuser;
			stamp_q <= s_tdata;
		end
		if (cmd.step1) begin
			delta_q <= stamp_q - last_stamp_q;
		end
		if (cmd.step2) begin
			scaled_q <= product[fts_pkg::SCALE_FRAC_BITS +: fts_pkg::SCALED_BITS];
		end
		if (cmd.step3) begin
			mean_num_q <= {32'd0, frame_count_q} * {32'd0, tps_q};
		end
		if (cmd.emit) begin
			out_data_q <= {mean_rate_q, highest_rate_q, lowest_rate_q, second_rate_q,
			               instant_rate_q, scaled_total_q, raw_elapsed_q, smooth_q,
			               kind_q ? 56'd0 : scaled_q, kind_q ? 48'd0 : delta_q,
			               frame_count_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign status.kind_clear   = kind_q;
	assign status.delta_zero   = (delta_q == '0);
	assign status.tps_zero     = (tps_q == '0);
	assign status.elapsed_zero = (raw_elapsed_q == '0);
	assign status.div_done     = div_done;
	assign status.out_blocked  = out_valid_q && !m_tready;

endmodule

// File: rtl/fts_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps

module fts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  fts_pkg::status_t  status,
	output fts_pkg::cmd_t     cmd
);

	fts_pkg::state_t state_q;
	fts_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fts_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next  = state_q;
		cmd         = '0;
		cmd.div_sel = fts_pkg::DIV_RATE;
		s_tready    = 1'b0;
		case (state_q)
			fts_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					state_next = fts_pkg::ST_STEP1;
				end
			end
			fts_pkg::ST_STEP1: begin
				if (status.kind_clear) begin
					cmd.clear  = 1'b1;
					state_next = fts_pkg::ST_EMIT;
				end else begin
					cmd.step1  = 1'b1;
					state_next = fts_pkg::ST_STEP2;
				end
			end
			fts_pkg::ST_STEP2: begin
				cmd.step2  = 1'b1;
				state_next = fts_pkg::ST_STEP3;
			end
			fts_pkg::ST_STEP3: begin
				cmd.step3 = 1'b1;
				if (status.delta_zero) begin
					state_next = fts_pkg::ST_SECS;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fts_pkg::DIV_RATE;
					state_next    = fts_pkg::ST_WAIT_RATE;
				end
			end
			fts_pkg::ST_WAIT_RATE: begin
				if (status.div_done) begin
					cmd.take_rate = 1'b1;
					state_next    = fts_pkg::ST_SECS;
				end
			end
			fts_pkg::ST_SECS: begin
				if (status.tps_zero) begin
					state_next = fts_pkg::ST_MINMAX;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fts_pkg::DIV_SECS;
					state_next    = fts_pkg::ST_WAIT_SECS;
				end
			end
			fts_pkg::ST_WAIT_SECS: begin
				cmd.div_sel = fts_pkg::DIV_SECS;
				if (status.div_done) begin
					cmd.take_secs = 1'b1;
					state_next    = fts_pkg::ST_MINMAX;
				end
			end
			fts_pkg::ST_MINMAX: begin
				cmd.minmax = 1'b1;
				if (status.elapsed_zero) begin
					cmd.mean_sat = 1'b1;
					state_next   = fts_pkg::ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fts_pkg::DIV_MEAN;
					state_next    = fts_pkg::ST_WAIT_MEAN;
				end
			end
			fts_pkg::ST_WAIT_MEAN: begin
				cmd.div_sel = fts_pkg::DIV_MEAN;
				if (status.div_done) begin
					cmd.take_mean = 1'b1;
					state_next    = fts_pkg::ST_EMIT;
				end
			end
			fts_pkg::ST_EMIT: begin
				if (!status.out_blocked) begin
					cmd.emit   = 1'b1;
					state_next = fts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = fts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/frame_timing_statistics_core.sv
// Top level of the frame timing statistics block.
`timescale 1ns / 1ps

// Each request is a frame-end timestamp or a statistics clear and yields one result.
// A clear passes from acceptance through the STEP1 and EMIT states to the result. A frame
// event computes the delta, the Q8.8 scaling multiply and the accumulators,
// then makes up to three passes of one shared radix-2 divider (for the
// instantaneous rate, the whole-second count and the average rate), each
// skipped when its divisor is zero. A new request is taken as soon as the
// previous result sits in the output register, even if it has not been taken yet.

module frame_timing_statistics_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [fts_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [fts_pkg::TPS_BITS-1:0]       cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [47:0]                        s_tdata,  // stamp[47:0]
	input  logic                               s_tuser,  // kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// frame_number[31:0], delta_ticks[79:32], scaled_delta[135:80],
	// smooth_delta[191:136], elapsed_ticks[255:192], scaled_elapsed[319:256],
	// rate_now[351:320], frames_last_second[383:352], rate_min[415:384],
	// rate_max[447:416], rate_avg[479:448]
	output logic [479:0]                       m_tdata
);

	fts_pkg::cmd_t    cmd;
	fts_pkg::status_t status;

	fts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A new request was accepted while one was in progress.");

	a_emit_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.out_blocked)
		else $error("A result overwrote one that had not been taken.");

	a_min_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[415:384] != fts_pkg::RATE_MAX)
		|-> m_tdata[415:384] <= m_tdata[447:416])
		else $error("Reported minimum rate exceeds maximum rate.");

	a_divider_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !s_tready && !cmd.emit)
		else $error("Divider finished while no division was pending.");

endmodule

// File: tb/sv/frame_timing_statistics_core_tb.sv
// Testbench for the frame timing statistics core: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module frame_timing_statistics_core_tb;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;
	localparam logic [fts_pkg::CFG_ADDR_BITS-1:0] REG_UNMAPPED = 8'hA5;
	localparam int PHASES = 10;
	localparam int PHASE_REQUESTS = 155;
	localparam int TAIL_CYCLES = 250;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic [31:0] rate_avg;
		logic [31:0] rate_max;
		logic [31:0] rate_min;
		logic [31:0] frames_last_second;
		logic [31:0] rate_now;
		logic [63:0] scaled_elapsed;
		logic [63:0] elapsed_ticks;
		logic [55:0] smooth_delta;
		logic [55:0] scaled_delta;
		logic [47:0] delta_ticks;
		logic [31:0] frame_number;
	} frame_stats_t;

	class frame_stats_scoreboard;
		bit [31:0] ticks_per_sec;
		bit [15:0] scale_q8;
		bit [47:0] prev_stamp;
		bit [63:0] elapsed;
		bit [63:0] scaled_sum;
		bit [55:0] smooth;
		bit [31:0] frames;
		bit [31:0] frames_at_boundary;
		bit [63:0] seconds_seen;
		bit [31:0] rate_now;
		bit [31:0] frames_in_second;
		bit [31:0] rate_low;
		bit [31:0] rate_high;
		bit [31:0] rate_mean;
		frame_stats_t stats_q[$];
		int errors;

		function new();
			ticks_per_sec = fts_pkg::TPS_RESET;
			scale_q8 = fts_pkg::SCALE_RESET;
			prev_stamp = '0;
			smooth = '0;
			errors = 0;
			clear_stats();
		endfunction

		function void clear_stats();
			elapsed = '0;
			scaled_sum = '0;
			frames = '0;
			frames_at_boundary = '0;
			seconds_seen = '0;
			rate_now = '0;
			frames_in_second = '0;
			rate_low = fts_pkg::RATE_MAX;
			rate_high = '0;
			rate_mean = '0;
		endfunction

		function bit [31:0] saturate(bit [63:0] v);
			if (v > {32'h0, fts_pkg::RATE_MAX})
				return fts_pkg::RATE_MAX;
			return v[31:0];
		endfunction

		function void write_register(bit [7:0] index, bit [31:0] value);
			if (index == fts_pkg::REG_TICKS_PER_SECOND)
				ticks_per_sec = value;
			else if (index == fts_pkg::REG_TIME_SCALE)
				scale_q8 = value[15:0];
		endfunction

		function int pending();
			return stats_q.size();
		endfunction

		function void note_request(bit kind, bit [47:0] stamp);
			frame_stats_t r;
			bit [47:0] diff;
			bit [63:0] delta;
			bit [63:0] product;
			bit [55:0] scaled;
			bit [63:0] secs;
			r = '0;
			if (kind == KIND_CLEAR) begin
				clear_stats();
			end else begin
				diff = stamp - prev_stamp;
				prev_stamp = stamp;
				delta = {16'h0, diff};
				product = delta * {48'h0, scale_q8};
				scaled = product[fts_pkg::SCALE_FRAC_BITS +: 56];
				elapsed += delta;
				scaled_sum += {8'h0, scaled};
				smooth = (smooth >> 1) + (scaled >> 1) + (smooth & scaled & 56'd1);
				frames += 1;
				if (delta != 0)
					rate_now = saturate({32'h0, ticks_per_sec} / delta);
				if (ticks_per_sec != 0) begin
					secs = elapsed / {32'h0, ticks_per_sec};
					if (secs != seconds_seen) begin
						frames_in_second = frames - frames_at_boundary;
						frames_at_boundary = frames;
						seconds_seen = secs;
					end
				end
				if (rate_now < rate_low)
					rate_low = rate_now;
				if (rate_now > rate_high)
					rate_high = rate_now;
				if (elapsed == 0)
					rate_mean = fts_pkg::RATE_MAX;
				else
					rate_mean = saturate(({32'h0, frames} * {32'h0, ticks_per_sec}) / elapsed);
				r.delta_ticks = diff;
				r.scaled_delta = scaled;
			end
			r.frame_number = frames;
			r.smooth_delta = smooth;
			r.elapsed_ticks = elapsed;
			r.scaled_elapsed = scaled_sum;
			r.rate_now = rate_now;
			r.frames_last_second = frames_in_second;
			r.rate_min = rate_low;
			r.rate_max = rate_high;
			r.rate_avg = rate_mean;
			stats_q.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		task compare_field(string name, bit [63:0] seen, bit [63:0] want);
			if (seen != want)
				report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, seen, want));
		endtask

		task check_result(logic [479:0] data);
			frame_stats_t got;
			frame_stats_t want;
			if (stats_q.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			got = data;
			want = stats_q.pop_front();
			if ($isunknown(data))
				report_mismatch("result holds unknown bits");
			compare_field("frame_number", got.frame_number, want.frame_number);
			compare_field("delta_ticks", got.delta_ticks, want.delta_ticks);
			compare_field("scaled_delta", got.scaled_delta, want.scaled_delta);
			compare_field("smooth_delta", got.smooth_delta, want.smooth_delta);
			compare_field("elapsed_ticks", got.elapsed_ticks, want.elapsed_ticks);
			compare_field("scaled_elapsed", got.scaled_elapsed, want.scaled_elapsed);
			compare_field("rate_now", got.rate_now, want.rate_now);
			compare_field("frames_last_second", got.frames_last_second,
				want.frames_last_second);
			compare_field("rate_min", got.rate_min, want.rate_min);
			compare_field("rate_max", got.rate_max, want.rate_max);
			compare_field("rate_avg", got.rate_avg, want.rate_avg);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [fts_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
	logic [fts_pkg::TPS_BITS-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [479:0] m_tdata;

	frame_stats_scoreboard sb;
	bit send_idle;
	bit recv_idle;
	bit [47:0] last_sent;

	frame_timing_statistics_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// All driving tasks start and end just after a falling edge.
	task automatic send_request(logic kind, logic [47:0] stamp);
		int gap;
		gap = send_idle ? $urandom_range(0, 6) : 0;
		if (gap != 0)
			repeat (gap) @(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = stamp;
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, stamp);
		if (kind == KIND_FRAME)
			last_sent = stamp;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic [7:0] index, logic [31:0] value);
		cfg_wen = 1'b1;
		cfg_addr = index;
		cfg_wdata = value;
		sb.write_register(index, value);
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic wait_results_drained();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic [31:0] tps, logic [15:0] scale);
		wait_results_drained();
		write_reg(fts_pkg::REG_TICKS_PER_SECOND, tps);
		write_reg(fts_pkg::REG_TIME_SCALE, {16'h0, scale});
	endtask

	task automatic run_phase(int count, logic [31:0] tps);
		int unsigned fps;
		int unsigned nominal;
		int unsigned jitter;
		int unsigned pick;
		logic [47:0] delta;
		case ($urandom_range(0, 4))
			0: fps = 24;
			1: fps = 30;
			2: fps = 60;
			3: fps = 144;
			default: fps = 1000;
		endcase
		nominal = (tps == 0) ? 16667 : tps / fps;
		if (nominal == 0)
			nominal = 1;
		jitter = nominal / 8;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				wait_results_drained();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_request(KIND_CLEAR, {16'($urandom), $urandom});
			end else begin
				if (pick < 83)
					delta = 48'(nominal - jitter + $urandom_range(0, 2 * jitter));
				else if (pick < 86)
					delta = '0;
				else if (pick < 93)
					delta = {16'($urandom), $urandom} - last_sent;
				else if (pick < 97)
					delta = 48'($urandom_range(1, 16));
				else
					delta = {16'($urandom), $urandom} | 48'h8000_0000_0000;
				send_request(KIND_FRAME, last_sent + delta);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tuser = KIND_FRAME;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		last_sent = '0;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: zero delta straight after reset, wrap of the stamp,
		// a held rate and a clear whose stamp must be ignored.
		send_request(KIND_CLEAR, 48'h0);
		send_request(KIND_FRAME, 48'h0);
		send_request(KIND_FRAME, 48'h1);
		send_request(KIND_FRAME, 48'd1000001);
		send_request(KIND_FRAME, 48'hFFFF_FFFF_FFFF);
		send_request(KIND_FRAME, 48'h10);
		send_request(KIND_FRAME, 48'h10);
		send_request(KIND_CLEAR, 48'hFFFF_FFFF_FFFF);
		send_request(KIND_FRAME, 48'h10);
		send_request(KIND_FRAME, 48'h10 + 48'd16667);

		// Largest settings: the average rate saturates, the scaled delta peaks.
		configure(32'hFFFF_FFFF, 16'hFFFF);
		write_reg(REG_UNMAPPED, 32'h0000_0003);
		send_request(KIND_CLEAR, 48'h0);
		send_request(KIND_FRAME, last_sent + 48'd1);
		send_request(KIND_FRAME, last_sent + 48'd1);
		send_request(KIND_FRAME, last_sent);
		send_request(KIND_FRAME, last_sent + 48'hFFFF_FFFF_FFFF);

		// Zero ticks per second: no second boundary and zero quotients.
		configure(32'h0, 16'h0);
		send_request(KIND_FRAME, last_sent + 48'd5000);
		send_request(KIND_FRAME, last_sent);
		send_request(KIND_CLEAR, 48'h0);

		configure(32'h1, 16'h1);
		send_request(KIND_FRAME, last_sent + 48'd1);
		send_request(KIND_FRAME, last_sent + 48'd3);
		send_request(KIND_FRAME, last_sent + 48'd2);

		for (int p = 0; p < PHASES; p++) begin
			logic [31:0] tps;
			logic [15:0] scale;
			case (p)
				0: begin tps = fts_pkg::TPS_RESET; scale = fts_pkg::SCALE_RESET; end
				1: begin tps = 32'hFFFF_FFFF; scale = 16'hFFFF; end
				2: begin tps = 32'h1; scale = 16'h0; end
				3: begin tps = 32'h0; scale = 16'($urandom); end
				default: begin
					case ($urandom_range(0, 3))
						0: tps = $urandom;
						1: tps = 32'd27000000;
						2: tps = 32'd90000;
						default: tps = $urandom_range(1, 5000);
					endcase
					scale = 16'($urandom);
				end
			endcase
			configure(tps, scale);
			send_idle = (p % 4 != 2) && ($urandom_range(0, 4) != 0);
			recv_idle = (p % 4 != 3) && ($urandom_range(0, 4) != 0);
			run_phase(PHASE_REQUESTS, tps);
		end

		while (sb.pending() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_idle ? $urandom_range(0, 6) : 0;
			@(negedge clk);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
